// ----- sv/unix_time_fat_timestamp_convert_core_macros.svh -----
// Assertion macros shared by the converter.
`ifndef UNIX_TIME_FAT_TIMESTAMP_CONVERT_CORE_MACROS_SVH
`define UNIX_TIME_FAT_TIMESTAMP_CONVERT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UTFC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/utfc_pkg.sv -----
`default_nettype none
package utfc_pkg;

    localparam int DivW = 34;
    localparam int RemW = 17;

    localparam logic [RemW-1:0] SecPerDay   = 17'd86400;
    localparam logic [RemW-1:0] SecPerHour  = 17'd3600;
    localparam logic [RemW-1:0] SecPerMin   = 17'd60;
    localparam logic [RemW-1:0] DaysPerWeek = 17'd7;

    // A whole number of days, large enough to make any local time positive.
    localparam logic signed [34:0] DayBiasSec = 35'sd2160000000;
    localparam logic [16:0]        DayBias    = 17'd25000;
    localparam logic [33:0]        WdayBias   = 34'd7340036;
    localparam logic [10:0]        SundayBias = 11'd700;
    localparam logic [7:0]         EpochYear  = 8'd70;
    localparam logic [7:0]         FatYearBase = 8'd80;
    localparam logic signed [10:0] LeapCut    = 11'sd58;
    localparam logic [3:0]         LastMonth  = 4'd11;
    localparam logic signed [34:0] HourSec    = 35'sd3600;

    typedef enum logic [1:0] {
        CFG_MINUTES_WEST = 2'd0,
        CFG_DST_RULE     = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_USA  = 3'd1,
        RULE_AUS  = 3'd2,
        RULE_WEST = 3'd3,
        RULE_MID  = 3'd4,
        RULE_EAST = 3'd5
    } t_rule;

    typedef struct packed {
        logic signed [11:0] minutes_west;
        logic [2:0]         dst_rule;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] unix_seconds;
        logic [15:0]        fat_time_in;
        logic [15:0]        fat_date_in;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        fat_time_out;
        logic [15:0]        fat_date_out;
        logic signed [31:0] result_seconds;
        logic               fields_invalid;
        logic               dst_applied;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_T_INIT, OP_CT_INIT, OP_CT_YEAR, OP_CT_LEAP, OP_CT_MON,
        OP_CT_MDAY, OP_CT_H, OP_CT_M, OP_CT_S, OP_CT_OFF, OP_T_FROM_CT,
        OP_DIV_DAY, OP_GET_DAY, OP_DIV_HOUR, OP_GET_HOUR, OP_DIV_MIN, OP_GET_MIN,
        OP_DIV_WDAY, OP_GET_WDAY, OP_YEAR, OP_YDAY, OP_MONTH, OP_BEGEND, OP_FS_ADJ,
        OP_DIV_FSB, OP_GET_FSB, OP_DIV_FSE, OP_GET_FSE, OP_DST
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_T_INIT, S_CT_INIT, S_CT_YEAR, S_CT_LEAP, S_CT_MON,
        S_CT_MDAY, S_CT_H, S_CT_M, S_CT_S, S_CT_OFF, S_T_FROM_CT,
        S_DAY_ST, S_DAY_WT, S_HOUR_ST, S_HOUR_WT, S_MIN_ST, S_MIN_WT,
        S_WD_ST, S_WD_WT, S_YEAR, S_YDAY, S_MONTH, S_BRANCH, S_BEGEND, S_FS_ADJ,
        S_FSB_ST, S_FSB_WT, S_FSE_ST, S_FSE_WT, S_DST, S_OUT
    } t_state;

    typedef struct packed {
        logic cmd;
        logic invalid;
        logic div_done;
        logic ct_year_done;
        logic ct_mon_done;
        logic year_done;
        logic month_done;
        logic rule_active;
        logic dst_on;
    } t_status;

    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] y);
        return 9'd365 + 9'(is_leap(y));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- sv/utfc_div.sv -----
`default_nettype none
module utfc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [utfc_pkg::DivW-1:0]   i_dividend,
    input  wire logic [utfc_pkg::RemW-1:0]   i_divisor,
    output logic                             o_done,
    output logic [utfc_pkg::DivW-1:0]        o_quotient,
    output logic [utfc_pkg::RemW-1:0]        o_remainder
);
    localparam int DivW = utfc_pkg::DivW;
    localparam int RemW = utfc_pkg::RemW;
    localparam int NumW = 27;
    localparam int MulW = 28;
    localparam int PrdW = NumW + MulW;

    // Each divisor is 2^p times a factor c. The quotient is ((x >> p) * ceil(2^k / c)) >> k,
    // which is exact for every 27-bit value of x >> p.
    localparam logic [MulW-1:0] RecipDay  = 28'd203613265;
    localparam logic [MulW-1:0] RecipHour = 28'd152709949;
    localparam logic [MulW-1:0] RecipMin  = 28'd143165577;
    localparam logic [MulW-1:0] RecipWeek = 28'd153391690;

    logic [2:0]      w_pre;
    logic [5:0]      w_post;
    logic [MulW-1:0] w_recip;

    logic            r_v_load;
    logic            r_v_prod;
    logic            r_v_quo;
    logic            r_done;
    logic [NumW-1:0] r_num;
    logic [MulW-1:0] r_recip;
    logic [5:0]      r_post;
    logic [RemW-1:0] r_dvs;
    logic [RemW-1:0] r_xlo;
    logic [PrdW-1:0] r_prod;
    logic [DivW-1:0] r_quo;
    logic [RemW-1:0] r_rem;

    always_comb begin
        case (i_divisor)
            utfc_pkg::SecPerDay: begin
                w_pre   = 3'd7;
                w_post  = 6'd37;
                w_recip = RecipDay;
            end
            utfc_pkg::SecPerHour: begin
                w_pre   = 3'd4;
                w_post  = 6'd35;
                w_recip = RecipHour;
            end
            utfc_pkg::SecPerMin: begin
                w_pre   = 3'd2;
                w_post  = 6'd31;
                w_recip = RecipMin;
            end
            default: begin
                w_pre   = 3'd0;
                w_post  = 6'd30;
                w_recip = RecipWeek;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_load <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_quo  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v_load <= i_start;
            r_v_prod <= r_v_load;
            r_v_quo  <= r_v_prod;
            r_done   <= r_v_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num   <= NumW'(i_dividend >> w_pre);
            r_recip <= w_recip;
            r_post  <= w_post;
            r_dvs   <= i_divisor;
            r_xlo   <= i_dividend[RemW-1:0];
        end
        if (r_v_load) r_prod <= PrdW'(r_num) * PrdW'(r_recip);
        if (r_v_prod) r_quo  <= DivW'(r_prod >> r_post);
        if (r_v_quo)  r_rem  <= r_xlo - RemW'(r_quo[RemW-1:0] * r_dvs);
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

// ----- sv/utfc_ctrl.sv -----
`default_nettype none
module utfc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire utfc_pkg::t_status  i_status,
    output utfc_pkg::t_op           o_op,
    output logic                    o_busy,
    output logic                    o_done
);
    utfc_pkg::t_state r_state, n_state;
    logic             r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utfc_pkg::S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            utfc_pkg::S_IDLE: begin
                n_pass = 1'b0;
                if (i_start) n_state = utfc_pkg::S_DISPATCH;
            end
            utfc_pkg::S_DISPATCH: begin
                if (!i_status.cmd)        n_state = utfc_pkg::S_T_INIT;
                else if (i_status.invalid) n_state = utfc_pkg::S_OUT;
                else                      n_state = utfc_pkg::S_CT_INIT;
            end
            utfc_pkg::S_T_INIT:    n_state = utfc_pkg::S_DAY_ST;
            utfc_pkg::S_CT_INIT:   n_state = utfc_pkg::S_CT_YEAR;
            utfc_pkg::S_CT_YEAR:   if (i_status.ct_year_done) n_state = utfc_pkg::S_CT_LEAP;
            utfc_pkg::S_CT_LEAP:   n_state = utfc_pkg::S_CT_MON;
            utfc_pkg::S_CT_MON:    if (i_status.ct_mon_done) n_state = utfc_pkg::S_CT_MDAY;
            utfc_pkg::S_CT_MDAY:   n_state = utfc_pkg::S_CT_H;
            utfc_pkg::S_CT_H:      n_state = utfc_pkg::S_CT_M;
            utfc_pkg::S_CT_M:      n_state = utfc_pkg::S_CT_S;
            utfc_pkg::S_CT_S:      n_state = utfc_pkg::S_CT_OFF;
            utfc_pkg::S_CT_OFF:    n_state = utfc_pkg::S_T_FROM_CT;
            utfc_pkg::S_T_FROM_CT: n_state = utfc_pkg::S_DAY_ST;
            utfc_pkg::S_DAY_ST:    n_state = utfc_pkg::S_DAY_WT;
            utfc_pkg::S_DAY_WT:    if (i_status.div_done) n_state = utfc_pkg::S_HOUR_ST;
            utfc_pkg::S_HOUR_ST:   n_state = utfc_pkg::S_HOUR_WT;
            utfc_pkg::S_HOUR_WT:   if (i_status.div_done) n_state = utfc_pkg::S_MIN_ST;
            utfc_pkg::S_MIN_ST:    n_state = utfc_pkg::S_MIN_WT;
            utfc_pkg::S_MIN_WT:    if (i_status.div_done) n_state = utfc_pkg::S_WD_ST;
            utfc_pkg::S_WD_ST:     n_state = utfc_pkg::S_WD_WT;
            utfc_pkg::S_WD_WT:     if (i_status.div_done) n_state = utfc_pkg::S_YEAR;
            utfc_pkg::S_YEAR:      if (i_status.year_done) n_state = utfc_pkg::S_YDAY;
            utfc_pkg::S_YDAY:      n_state = utfc_pkg::S_MONTH;
            utfc_pkg::S_MONTH:     if (i_status.month_done) n_state = utfc_pkg::S_BRANCH;
            utfc_pkg::S_BRANCH: begin
                if (r_pass || !i_status.rule_active) n_state = utfc_pkg::S_OUT;
                else                                 n_state = utfc_pkg::S_BEGEND;
            end
            utfc_pkg::S_BEGEND:    n_state = utfc_pkg::S_FS_ADJ;
            utfc_pkg::S_FS_ADJ:    n_state = utfc_pkg::S_FSB_ST;
            utfc_pkg::S_FSB_ST:    n_state = utfc_pkg::S_FSB_WT;
            utfc_pkg::S_FSB_WT:    if (i_status.div_done) n_state = utfc_pkg::S_FSE_ST;
            utfc_pkg::S_FSE_ST:    n_state = utfc_pkg::S_FSE_WT;
            utfc_pkg::S_FSE_WT:    if (i_status.div_done) n_state = utfc_pkg::S_DST;
            utfc_pkg::S_DST: begin
                if (i_status.dst_on && !i_status.cmd) begin
                    n_pass  = 1'b1;
                    n_state = utfc_pkg::S_DAY_ST;
                end else begin
                    n_state = utfc_pkg::S_OUT;
                end
            end
            utfc_pkg::S_OUT:       n_state = utfc_pkg::S_IDLE;
            default:               n_state = utfc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = utfc_pkg::OP_NONE;
        o_busy = (r_state != utfc_pkg::S_IDLE);
        o_done = (r_state == utfc_pkg::S_OUT);
        case (r_state)
            utfc_pkg::S_IDLE:      if (i_start) o_op = utfc_pkg::OP_LOAD;
            utfc_pkg::S_T_INIT:    o_op = utfc_pkg::OP_T_INIT;
            utfc_pkg::S_CT_INIT:   o_op = utfc_pkg::OP_CT_INIT;
            utfc_pkg::S_CT_YEAR:   if (!i_status.ct_year_done) o_op = utfc_pkg::OP_CT_YEAR;
            utfc_pkg::S_CT_LEAP:   o_op = utfc_pkg::OP_CT_LEAP;
            utfc_pkg::S_CT_MON:    if (!i_status.ct_mon_done) o_op = utfc_pkg::OP_CT_MON;
            utfc_pkg::S_CT_MDAY:   o_op = utfc_pkg::OP_CT_MDAY;
            utfc_pkg::S_CT_H:      o_op = utfc_pkg::OP_CT_H;
            utfc_pkg::S_CT_M:      o_op = utfc_pkg::OP_CT_M;
            utfc_pkg::S_CT_S:      o_op = utfc_pkg::OP_CT_S;
            utfc_pkg::S_CT_OFF:    o_op = utfc_pkg::OP_CT_OFF;
            utfc_pkg::S_T_FROM_CT: o_op = utfc_pkg::OP_T_FROM_CT;
            utfc_pkg::S_DAY_ST:    o_op = utfc_pkg::OP_DIV_DAY;
            utfc_pkg::S_DAY_WT:    if (i_status.div_done) o_op = utfc_pkg::OP_GET_DAY;
            utfc_pkg::S_HOUR_ST:   o_op = utfc_pkg::OP_DIV_HOUR;
            utfc_pkg::S_HOUR_WT:   if (i_status.div_done) o_op = utfc_pkg::OP_GET_HOUR;
            utfc_pkg::S_MIN_ST:    o_op = utfc_pkg::OP_DIV_MIN;
            utfc_pkg::S_MIN_WT:    if (i_status.div_done) o_op = utfc_pkg::OP_GET_MIN;
            utfc_pkg::S_WD_ST:     o_op = utfc_pkg::OP_DIV_WDAY;
            utfc_pkg::S_WD_WT:     if (i_status.div_done) o_op = utfc_pkg::OP_GET_WDAY;
            utfc_pkg::S_YEAR:      if (!i_status.year_done) o_op = utfc_pkg::OP_YEAR;
            utfc_pkg::S_YDAY:      o_op = utfc_pkg::OP_YDAY;
            utfc_pkg::S_MONTH:     if (!i_status.month_done) o_op = utfc_pkg::OP_MONTH;
            utfc_pkg::S_BEGEND:    o_op = utfc_pkg::OP_BEGEND;
            utfc_pkg::S_FS_ADJ:    o_op = utfc_pkg::OP_FS_ADJ;
            utfc_pkg::S_FSB_ST:    o_op = utfc_pkg::OP_DIV_FSB;
            utfc_pkg::S_FSB_WT:    if (i_status.div_done) o_op = utfc_pkg::OP_GET_FSB;
            utfc_pkg::S_FSE_ST:    o_op = utfc_pkg::OP_DIV_FSE;
            utfc_pkg::S_FSE_WT:    if (i_status.div_done) o_op = utfc_pkg::OP_GET_FSE;
            utfc_pkg::S_DST:       if (i_status.dst_on) o_op = utfc_pkg::OP_DST;
            default:               o_op = utfc_pkg::OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/utfc_dp.sv -----
`default_nettype none
module utfc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire utfc_pkg::t_op       i_op,
    input  wire utfc_pkg::t_in_word  i_word,
    input  wire utfc_pkg::t_cfg      i_cfg,
    output utfc_pkg::t_status        o_status,
    output utfc_pkg::t_out_word      o_word
);
    localparam int DivW = utfc_pkg::DivW;
    localparam int RemW = utfc_pkg::RemW;

    logic               r_cmd;
    logic signed [31:0] r_unix;
    logic [15:0]        r_ftime;
    logic [15:0]        r_fdate;
    logic signed [34:0] r_t;
    logic signed [16:0] r_day;
    logic [7:0]         r_y;
    logic [16:0]        r_hms;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;
    logic [8:0]         r_yday;
    logic [2:0]         r_wday;
    logic [3:0]         r_m;
    logic [8:0]         r_d;
    logic signed [10:0] r_beg;
    logic signed [10:0] r_end;
    logic               r_south;
    logic               r_dst;
    logic [31:0]        r_ct;
    logic [7:0]         r_i;

    logic [4:0]  f_sec2;
    logic [5:0]  f_min;
    logic [4:0]  f_hour;
    logic [4:0]  f_mday;
    logic [3:0]  f_mon;
    logic [7:0]  w_fyear;
    logic [3:0]  w_fmon0;
    logic        w_invalid;
    logic signed [18:0] w_off;

    logic               w_div_start;
    logic [DivW-1:0]    w_dividend;
    logic [RemW-1:0]    w_divisor;
    logic               w_div_done;
    logic [DivW-1:0]    w_quo;
    logic [RemW-1:0]    w_rem;

    logic signed [16:0] w_len_s;
    logic signed [16:0] w_lenm_s;
    logic [8:0]         w_mlen;
    logic signed [10:0] w_beg_raw;
    logic signed [10:0] w_end_raw;
    logic               w_south;
    logic               w_rule_active;
    logic signed [10:0] w_yd;
    logic               w_after_beg;
    logic               w_before_end;
    logic               w_on;
    logic [10:0]        w_fsb;
    logic [10:0]        w_fse;

    always_comb begin
        f_sec2    = r_ftime[4:0];
        f_min     = r_ftime[10:5];
        f_hour    = r_ftime[15:11];
        f_mday    = r_fdate[4:0];
        f_mon     = r_fdate[8:5];
        w_fyear   = utfc_pkg::FatYearBase + {1'b0, r_fdate[15:9]};
        w_fmon0   = f_mon - 4'd1;
        w_invalid = (f_mon == 4'd0) || (f_mon > 4'd12) || (f_mday == 5'd0) ||
                    (f_hour > 5'd23) || (f_min > 6'd59) || (f_sec2 > 5'd29);
        w_off     = 19'(i_cfg.minutes_west) * 19'sd60;
    end

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = 34'(r_hms);
        w_divisor   = utfc_pkg::SecPerHour;
        case (i_op)
            utfc_pkg::OP_DIV_DAY: begin
                w_div_start = 1'b1;
                w_dividend  = DivW'(r_t + utfc_pkg::DayBiasSec);
                w_divisor   = utfc_pkg::SecPerDay;
            end
            utfc_pkg::OP_DIV_HOUR: begin
                w_div_start = 1'b1;
            end
            utfc_pkg::OP_DIV_MIN: begin
                w_div_start = 1'b1;
                w_divisor   = utfc_pkg::SecPerMin;
            end
            utfc_pkg::OP_DIV_WDAY: begin
                w_div_start = 1'b1;
                w_dividend  = DivW'(r_day) + utfc_pkg::WdayBias;
                w_divisor   = utfc_pkg::DaysPerWeek;
            end
            utfc_pkg::OP_DIV_FSB: begin
                w_div_start = 1'b1;
                w_dividend  = DivW'(w_fsb);
                w_divisor   = utfc_pkg::DaysPerWeek;
            end
            utfc_pkg::OP_DIV_FSE: begin
                w_div_start = 1'b1;
                w_dividend  = DivW'(w_fse);
                w_divisor   = utfc_pkg::DaysPerWeek;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    utfc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        w_len_s  = signed'(17'(utfc_pkg::year_len(r_y)));
        w_lenm_s = signed'(17'(utfc_pkg::year_len(r_y - 8'd1)));
        w_mlen   = 9'(utfc_pkg::month_len(r_m, utfc_pkg::is_leap(r_y)));
        w_fsb    = 11'(r_beg) - 11'(r_yday) + 11'(r_wday) + utfc_pkg::SundayBias;
        w_fse    = 11'(r_end) - 11'(r_yday) + 11'(r_wday) + utfc_pkg::SundayBias;
    end

    always_comb begin
        w_south       = 1'b0;
        w_rule_active = 1'b1;
        w_beg_raw     = 11'sd400;
        w_end_raw     = 11'sd0;
        case (i_cfg.dst_rule)
            utfc_pkg::RULE_USA: begin
                if (r_y == 8'd74) begin
                    w_beg_raw = 11'sd5;   w_end_raw = 11'sd333;
                end else if (r_y == 8'd75) begin
                    w_beg_raw = 11'sd58;  w_end_raw = 11'sd303;
                end else begin
                    w_beg_raw = 11'sd119; w_end_raw = 11'sd303;
                end
            end
            utfc_pkg::RULE_AUS: begin
                w_south = 1'b1;
                if (r_y == 8'd70) begin
                    w_beg_raw = 11'sd400; w_end_raw = 11'sd0;
                end else if (r_y == 8'd71) begin
                    w_beg_raw = 11'sd303; w_end_raw = 11'sd0;
                end else if (r_y == 8'd72) begin
                    w_beg_raw = 11'sd303; w_end_raw = 11'sd58;
                end else begin
                    w_beg_raw = 11'sd303; w_end_raw = 11'sd65;
                end
            end
            utfc_pkg::RULE_WEST: begin
                if (r_y >= 8'd83 && r_y <= 8'd85) begin
                    w_beg_raw = 11'sd86; w_end_raw = 11'sd303;
                end
            end
            utfc_pkg::RULE_MID, utfc_pkg::RULE_EAST: begin
                if (r_y >= 8'd83 && r_y <= 8'd85) begin
                    w_beg_raw = 11'sd86; w_end_raw = 11'sd272;
                end
            end
            default: w_rule_active = 1'b0;
        endcase
    end

    always_comb begin
        w_yd         = signed'({2'b00, r_yday});
        w_after_beg  = (w_yd > r_beg) || ((w_yd == r_beg) && (r_hour >= 5'd2));
        if (r_south) begin
            w_before_end = (w_yd < r_end) || ((w_yd == r_end) && (r_hour < 5'd2));
            w_on         = w_after_beg || w_before_end;
        end else begin
            w_before_end = (w_yd < r_end) || ((w_yd == r_end) && (r_hour < 5'd1));
            w_on         = w_after_beg && w_before_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= 1'b0;
            r_dst <= 1'b0;
        end else begin
            case (i_op)
                utfc_pkg::OP_LOAD: begin
                    r_cmd <= i_word.cmd;
                    r_dst <= 1'b0;
                end
                utfc_pkg::OP_DST:  r_dst <= 1'b1;
                default:           r_dst <= r_dst;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            utfc_pkg::OP_LOAD: begin
                r_unix  <= i_word.unix_seconds;
                r_ftime <= i_word.fat_time_in;
                r_fdate <= i_word.fat_date_in;
            end
            utfc_pkg::OP_T_INIT:    r_t <= 35'(r_unix) - 35'(w_off);
            utfc_pkg::OP_CT_INIT: begin
                r_ct <= '0;
                r_i  <= utfc_pkg::EpochYear;
            end
            utfc_pkg::OP_CT_YEAR: begin
                r_ct <= r_ct + 32'(utfc_pkg::year_len(r_i));
                r_i  <= r_i + 8'd1;
            end
            utfc_pkg::OP_CT_LEAP: begin
                if (utfc_pkg::is_leap(w_fyear) && (f_mon >= 4'd3)) r_ct <= r_ct + 32'd1;
                r_m <= '0;
            end
            utfc_pkg::OP_CT_MON: begin
                r_ct <= r_ct + 32'(utfc_pkg::month_len(r_m, 1'b0));
                r_m  <= r_m + 4'd1;
            end
            utfc_pkg::OP_CT_MDAY:   r_ct <= r_ct + 32'(f_mday) - 32'd1;
            utfc_pkg::OP_CT_H:      r_ct <= r_ct * 32'd24 + 32'(f_hour);
            utfc_pkg::OP_CT_M:      r_ct <= r_ct * 32'd60 + 32'(f_min);
            utfc_pkg::OP_CT_S:      r_ct <= r_ct * 32'd60 + 32'({f_sec2, 1'b0});
            utfc_pkg::OP_CT_OFF:    r_ct <= r_ct + 32'(w_off);
            utfc_pkg::OP_T_FROM_CT: r_t  <= 35'(signed'(r_ct)) - 35'(w_off);
            utfc_pkg::OP_GET_DAY: begin
                r_day <= signed'(w_quo[16:0] - utfc_pkg::DayBias);
                r_hms <= w_rem;
            end
            utfc_pkg::OP_GET_HOUR: begin
                r_hour <= w_quo[4:0];
                r_hms  <= w_rem;
            end
            utfc_pkg::OP_GET_MIN: begin
                r_min <= w_quo[5:0];
                r_sec <= w_rem[5:0];
            end
            utfc_pkg::OP_GET_WDAY: begin
                r_wday <= w_rem[2:0];
                r_y    <= utfc_pkg::EpochYear;
            end
            utfc_pkg::OP_YEAR: begin
                if (!r_day[16]) begin
                    r_day <= r_day - w_len_s;
                    r_y   <= r_y + 8'd1;
                end else begin
                    r_day <= r_day + w_lenm_s;
                    r_y   <= r_y - 8'd1;
                end
            end
            utfc_pkg::OP_YDAY: begin
                r_yday <= r_day[8:0];
                r_d    <= r_day[8:0];
                r_m    <= '0;
            end
            utfc_pkg::OP_MONTH: begin
                r_d <= r_d - w_mlen;
                r_m <= r_m + 4'd1;
            end
            utfc_pkg::OP_BEGEND: begin
                r_beg   <= w_beg_raw;
                r_end   <= w_end_raw;
                r_south <= w_south;
            end
            utfc_pkg::OP_FS_ADJ: begin
                if (r_beg >= utfc_pkg::LeapCut) r_beg <= r_beg + 11'(utfc_pkg::is_leap(r_y));
                if (r_end >= utfc_pkg::LeapCut) r_end <= r_end + 11'(utfc_pkg::is_leap(r_y));
            end
            utfc_pkg::OP_GET_FSB:   r_beg <= r_beg - signed'(11'(w_rem[2:0]));
            utfc_pkg::OP_GET_FSE:   r_end <= r_end - signed'(11'(w_rem[2:0]));
            utfc_pkg::OP_DST:       r_t   <= r_t + utfc_pkg::HourSec;
            default:                r_i   <= r_i;
        endcase
    end

    always_comb begin
        o_status.cmd          = r_cmd;
        o_status.invalid      = w_invalid;
        o_status.div_done     = w_div_done;
        o_status.ct_year_done = (r_i >= w_fyear);
        o_status.ct_mon_done  = (r_m >= w_fmon0);
        o_status.year_done    = !r_day[16] && (r_day < w_len_s);
        o_status.month_done   = (r_m == utfc_pkg::LastMonth) || (r_d < w_mlen);
        o_status.rule_active  = w_rule_active;
        o_status.dst_on       = w_on;
    end

    always_comb begin
        o_word = '0;
        if (!r_cmd) begin
            o_word.fat_time_out = {r_hour, r_min, r_sec[5:1]};
            o_word.fat_date_out = {r_y[6:0] - utfc_pkg::FatYearBase[6:0], r_m + 4'd1,
                                   r_d[4:0] + 5'd1};
            o_word.dst_applied  = r_dst;
        end else if (w_invalid) begin
            o_word.fields_invalid = 1'b1;
        end else begin
            o_word.result_seconds = signed'(r_dst ? (r_ct - 32'd3600) : r_ct);
            o_word.dst_applied    = r_dst;
        end
    end
endmodule
`default_nettype wire

// ----- sv/unix_time_fat_timestamp_convert_core.sv -----
// Channel   Direction  Handshake                     Payload
// command   in         i_start, o_busy               i_word (utfc_pkg::t_in_word)
// result    out        o_done (one-cycle strobe)     o_word (utfc_pkg::t_out_word)
// config    in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
// One word is in flight at a time; o_busy stays high from acceptance to the result strobe.
// A word with rejected fields goes from dispatch straight to its strobe; any other word
// makes four, six or ten passes through the shared reciprocal divider and steps through
// each year and each month on the way.
// The synchronous reset clears the controller and both configuration registers.
// The result strobe lasts one cycle and the receiver cannot stall it; config is always ready.
`default_nettype none
`include "unix_time_fat_timestamp_convert_core_macros.svh"
module unix_time_fat_timestamp_convert_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire utfc_pkg::t_in_word   i_word,
    output logic                      o_busy,
    output logic                      o_done,
    output utfc_pkg::t_out_word       o_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [11:0]          i_cfg_data
);
    utfc_pkg::t_cfg    r_cfg;
    utfc_pkg::t_op     w_op;
    utfc_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                utfc_pkg::CFG_MINUTES_WEST: r_cfg.minutes_west <= signed'(i_cfg_data);
                utfc_pkg::CFG_DST_RULE:     r_cfg.dst_rule     <= i_cfg_data[2:0];
                default:                    r_cfg              <= r_cfg;
            endcase
        end
    end

    utfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    utfc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_word   (i_word),
        .i_cfg    (r_cfg),
        .o_status (w_status),
        .o_word   (o_word)
    );

    `UTFC_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted word did not raise busy")
    `UTFC_ASSERT_SAME(a_done_busy, o_done, o_busy, "result strobe outside a conversion")
    `UTFC_ASSERT_NEXT(a_done_single, o_done, !o_done && !o_busy, "result strobe longer than a cycle")
    `UTFC_ASSERT_SAME(a_invalid_zero, o_done && o_word.fields_invalid, (o_word.result_seconds == 32'sd0) && !o_word.dst_applied, "rejected fields gave a non-zero result")
endmodule
`default_nettype wire
